// ===== hdl/ihb_pkg.sv =====
package ihb_pkg;

   localparam int WORD_W    = 32;
   localparam int IDX_W     = 31;
   localparam int ROT_LEFT  = 5;
   localparam int DIV_CNT_W = $clog2(WORD_W + 1);

   localparam logic [IDX_W-1:0] TABLE_RESET = IDX_W'(1024);

   localparam logic [WORD_W-1:0] MIX_C0 = 32'h7ed55d16;
   localparam logic [WORD_W-1:0] MIX_C1 = 32'hc761c23c;
   localparam logic [WORD_W-1:0] MIX_C2 = 32'h165667b1;
   localparam logic [WORD_W-1:0] MIX_C3 = 32'hd3a2646c;
   localparam logic [WORD_W-1:0] MIX_C4 = 32'hfd7046c5;
   localparam logic [WORD_W-1:0] MIX_C5 = 32'hb55a4f09;

   typedef enum logic [2:0] {
      STEP_ADD12,
      STEP_XOR19,
      STEP_ADD5,
      STEP_XADD9,
      STEP_ADD3,
      STEP_XOR16
   } mix_step_type;

   typedef struct packed {
      logic start;
      logic take;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic valid;
   } div_stat_type;

   function automatic logic [WORD_W-1:0] mix_step(input mix_step_type step,
                                                  input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      case (step)
         STEP_ADD12: r = (v + MIX_C0) + (v << 12);
         STEP_XOR19: r = (v ^ MIX_C1) ^ (v >> 19);
         STEP_ADD5:  r = (v + MIX_C2) + (v << 5);
         STEP_XADD9: r = (v + MIX_C3) ^ (v << 9);
         STEP_ADD3:  r = (v + MIX_C4) + (v << 3);
         STEP_XOR16: r = (v ^ MIX_C5) ^ (v >> 16);
         default:    r = v;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v);
      return (v << ROT_LEFT) | (v >> (WORD_W - ROT_LEFT));
   endfunction

endpackage

// ===== hdl/ihb_if.sv =====
interface ihb_req_if;
   logic                       valid;
   logic                       ready;
   logic [ihb_pkg::WORD_W-1:0] key_word;
   logic                       last_word;

   modport source(output valid, output key_word, output last_word, input ready);
   modport sink(input valid, input key_word, input last_word, output ready);
endinterface

interface ihb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ihb_pkg::IDX_W-1:0] bucket_index;

   modport source(output valid, output bucket_index, input ready);
   modport sink(input valid, input bucket_index, output ready);
endinterface

// ===== hdl/ihb_mixer.sv =====
module ihb_mixer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ihb_pkg::WORD_W-1:0] word,
   output logic                       done,
   output logic [ihb_pkg::WORD_W-1:0] mixed
);

   logic                       busy_ff;
   logic                       done_ff;
   ihb_pkg::mix_step_type      step_ff;
   logic [ihb_pkg::WORD_W-1:0] v_ff;
   logic [ihb_pkg::WORD_W-1:0] v_in;

   assign v_in = ihb_pkg::mix_step(step_ff, v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= ihb_pkg::STEP_ADD12;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            step_ff <= ihb_pkg::STEP_ADD12;
         end else if (busy_ff) begin
            if (step_ff == ihb_pkg::STEP_XOR16) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff <= 1'b0;
               step_ff <= ihb_pkg::mix_step_type'(step_ff + 3'd1);
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   // one mix step per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= word;
      end else if (busy_ff) begin
         v_ff <= v_in;
      end
   end

   assign done  = done_ff;
   assign mixed = v_ff;

endmodule

// ===== hdl/ihb_divider.sv =====
module ihb_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  ihb_pkg::div_ctl_type       ctl,
   input  logic [ihb_pkg::WORD_W-1:0] dividend,
   input  logic [ihb_pkg::IDX_W-1:0]  divisor,
   output ihb_pkg::div_stat_type      stat,
   output logic [ihb_pkg::IDX_W-1:0]  remainder
);

   logic                          busy_ff;
   logic                          valid_ff;
   logic [ihb_pkg::DIV_CNT_W-1:0] count_ff;
   logic [ihb_pkg::WORD_W-1:0]    shift_ff;
   logic [ihb_pkg::IDX_W-1:0]     rem_ff;
   logic [ihb_pkg::IDX_W-1:0]     rem_in;
   logic [ihb_pkg::IDX_W-1:0]     divisor_ff;
   logic                          zero_ff;
   logic [ihb_pkg::IDX_W:0]       trial;

   // bring in the next dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, shift_ff[ihb_pkg::WORD_W-1]};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = ihb_pkg::IDX_W'(trial - {1'b0, divisor_ff});
      end else begin
         rem_in = trial[ihb_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (ctl.take) begin
            valid_ff <= 1'b0;
         end
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            valid_ff <= 1'b0;
            count_ff <= ihb_pkg::DIV_CNT_W'(ihb_pkg::WORD_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == ihb_pkg::DIV_CNT_W'(1)) begin
               busy_ff  <= 1'b0;
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         shift_ff   <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         zero_ff    <= (divisor == '0);
      end else if (busy_ff) begin
         shift_ff <= shift_ff << 1;
         rem_ff   <= rem_in;
      end
   end

   assign stat.busy  = busy_ff;
   assign stat.valid = valid_ff;
   assign remainder  = zero_ff ? '0 : rem_ff;

endmodule

// ===== hdl/int_array_hash_bucket_top.sv =====
// Bucket index hash over keys made of 32-bit words.
// req_ch carries one key word per item with last_word set on the final word
// of a key; rsp_ch returns one bucket_index item per key. csr_we/csr_wdata
// write the table size (bucket count); the user must write it only while
// the block is idle, the block itself does not enforce this. Each word runs
// through a six-step mix sequencer, one step per cycle, and is folded into
// the running hash: a word without last_word frees the input once its mix
// is done. On the last word the hash is reduced by a bit-serial remainder
// unit, one dividend bit per cycle; the input is free again in the same
// cycle as the result is registered. A table size of zero gives bucket 0.
// The result sits in an output register; the block accepts the next key's
// words while it waits. If the receiver still stalls when the next key's
// remainder is done, that remainder is held in the divider until the
// output register drains.
// Reset clears the running hash, empties the output and sets the table
// size to 1024.
module int_array_hash_bucket_top (
   input  logic                      clock,
   input  logic                      reset,
   ihb_req_if.sink                   req_ch,
   ihb_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [ihb_pkg::IDX_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_DIV
   } state_type;

   state_type                  state_ff;
   logic [ihb_pkg::WORD_W-1:0] hash_ff;
   logic [ihb_pkg::WORD_W-1:0] hash_in;
   logic                       last_ff;
   logic [ihb_pkg::IDX_W-1:0]  table_size_ff;
   logic                       rsp_valid_ff;
   logic [ihb_pkg::IDX_W-1:0]  rsp_index_ff;

   logic                       accept;
   logic                       mix_done;
   logic [ihb_pkg::WORD_W-1:0] mixed;
   ihb_pkg::div_ctl_type       div_ctl;
   ihb_pkg::div_stat_type      div_stat;
   logic [ihb_pkg::IDX_W-1:0]  div_rem;
   logic                       out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign hash_in      = ihb_pkg::rot_left(hash_ff) ^ mixed;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign div_ctl.start = (state_ff == ST_MIX) && mix_done && last_ff;
   assign div_ctl.take  = (state_ff == ST_DIV) && div_stat.valid && out_free;

   ihb_mixer u_mixer (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .word  (req_ch.key_word),
      .done  (mix_done),
      .mixed (mixed)
   );

   ihb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (hash_in),
      .divisor   (table_size_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hash_ff       <= '0;
         last_ff       <= 1'b0;
         table_size_ff <= ihb_pkg::TABLE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            table_size_ff <= csr_wdata;
         end
         // move the remainder out once the output register is free
         if (div_ctl.take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff  <= req_ch.last_word;
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: begin
               if (mix_done) begin
                  if (last_ff) begin
                     hash_ff  <= '0;
                     state_ff <= ST_DIV;
                  end else begin
                     hash_ff  <= hash_in;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_DIV: begin
               if (div_ctl.take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (div_ctl.take) begin
         rsp_index_ff <= div_rem;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bucket_index = rsp_index_ff;

endmodule
